[hdl/ahe_pkg.sv]
// Shared types, constants and helper functions of the ampersand hex escape codec.
`timescale 1ns / 1ps

package ahe_pkg;

    // Default width of one code unit that takes part in the codec.
    localparam int CHAR_BITS_DEF = 16;
    // Default number of command entries between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Character codes used by the escape syntax.
    localparam logic [15:0] AMP_CODE  = 16'h0026;
    localparam logic [15:0] SEMI_CODE = 16'h003B;

    // Direction register values.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Decoder phase.
    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_AMP    = 2'd1,
        PH_DIGITS = 2'd2,
        PH_SKIP   = 2'd3
    } t_phase;

    // Error code carried with each result.
    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_NO_DIGIT     = 2'd1,
        ERR_UNTERMINATED = 2'd2
    } t_err;

    // What the back end has to emit for one accepted input item.
    typedef enum logic [1:0] {
        CMD_NONE     = 2'd0,
        CMD_CHAR     = 2'd1,
        CMD_ESCAPE   = 2'd2,
        CMD_NO_DIGIT = 2'd3
    } t_cmd_kind;

    // One queued command.
    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] chr;
        logic [2:0]  ndig;  // hex digits of an escape, 1 to 4
        logic        err2;  // append an unterminated-escape result
        logic        last;  // final item of the text
    } t_cmd;

    // One result item.
    typedef struct packed {
        t_err        err;
        logic        valid;
        logic [15:0] chr;
    } t_result;

    // Value of a hex digit, with a flag that says the code is a hex digit.
    function automatic logic [4:0] hex_value(input logic [15:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 16'h0041 && c <= 16'h0046) ||
                     (c >= 16'h0061 && c <= 16'h0066)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Control characters, whitespace and the ampersand are escaped.
    function automatic logic needs_escape(input logic [15:0] c);
        logic cntrl;
        logic space;
        cntrl = (c <= 16'h001F) || (c >= 16'h007F && c <= 16'h009F);
        space = (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
                c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
                c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
                c == 16'h3000;
        return cntrl || space || c == AMP_CODE;
    endfunction

    // Uppercase ASCII hex digit of a nibble.
    function automatic logic [15:0] hex_ascii(input logic [3:0] d);
        logic [15:0] r;
        if (d < 4'd10) begin
            r = 16'h0030 + {12'd0, d};
        end else begin
            r = 16'h0037 + {12'd0, d};
        end
        return r;
    endfunction

endpackage

[hdl/ahe_front.sv]
// Front end: accepts code units, tracks the decoder phase and issues commands.
`timescale 1ns / 1ps

module ahe_front #(
    parameter int CHAR_BITS = ahe_pkg::CHAR_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_data,
    input  logic          i_valid,
    input  logic [15:0]   i_char,
    input  logic          i_last,
    input  logic          i_space,   // queue can take a command
    output logic          o_push,
    output ahe_pkg::t_cmd o_cmd
);
    import ahe_pkg::*;

    localparam logic [15:0] UnitMask = (CHAR_BITS >= 16) ? 16'hFFFF :
                                       16'((32'd1 << CHAR_BITS) - 32'd1);

    logic        r_dir;
    t_phase      r_phase;
    t_phase      n_phase;
    t_phase      w_phase_upd;
    logic [15:0] r_acc;
    logic [15:0] n_acc;
    logic [15:0] w_acc_upd;
    logic [15:0] w_c;
    logic [4:0]  w_hex;
    logic        w_is_hex;
    logic        w_accept;

    assign w_accept = i_valid && i_space;
    // A unit that gives no result and does not end the text queues nothing.
    assign o_push   = w_accept && (o_cmd.kind != CMD_NONE || i_last);
    assign w_c      = i_char & UnitMask;
    assign w_hex    = hex_value(w_c);
    assign w_is_hex = w_hex[4];

    // Decoder phase step for the current code unit.
    always_comb begin
        w_phase_upd = r_phase;
        w_acc_upd   = r_acc;
        if (r_dir == DIR_DECODE) begin
            unique case (r_phase)
                PH_NORMAL: begin
                    if (w_c == AMP_CODE) begin
                        w_phase_upd = PH_AMP;
                        w_acc_upd   = 16'd0;
                    end
                end
                PH_AMP: begin
                    if (w_is_hex) begin
                        w_phase_upd = PH_DIGITS;
                        w_acc_upd   = {12'd0, w_hex[3:0]};
                    end else begin
                        w_phase_upd = (w_c == SEMI_CODE) ? PH_NORMAL : PH_SKIP;
                    end
                end
                PH_DIGITS: begin
                    if (w_is_hex) begin
                        w_acc_upd = {r_acc[11:0], w_hex[3:0]};
                    end else begin
                        w_phase_upd = (w_c == SEMI_CODE) ? PH_NORMAL : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (w_c == SEMI_CODE) begin
                        w_phase_upd = PH_NORMAL;
                    end
                end
                default: begin
                    w_phase_upd = PH_NORMAL;
                end
            endcase
        end
    end

    // Next state: a configuration write or the end of the text clears the phase.
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        if (i_cfg_valid) begin
            n_phase = PH_NORMAL;
            n_acc   = 16'd0;
        end else if (w_accept) begin
            if (i_last) begin
                n_phase = PH_NORMAL;
                n_acc   = 16'd0;
            end else begin
                n_phase = w_phase_upd;
                n_acc   = w_acc_upd;
            end
        end
    end

    // Command for the back end.
    always_comb begin
        o_cmd.kind = CMD_NONE;
        o_cmd.chr  = w_c;
        o_cmd.ndig = 3'd1;
        o_cmd.err2 = 1'b0;
        o_cmd.last = i_last;
        if (w_c[15:12] != 4'd0) begin
            o_cmd.ndig = 3'd4;
        end else if (w_c[11:8] != 4'd0) begin
            o_cmd.ndig = 3'd3;
        end else if (w_c[7:4] != 4'd0) begin
            o_cmd.ndig = 3'd2;
        end
        if (r_dir == DIR_ENCODE) begin
            o_cmd.kind = needs_escape(w_c) ? CMD_ESCAPE : CMD_CHAR;
        end else begin
            o_cmd.err2 = i_last && (w_phase_upd != PH_NORMAL);
            unique case (r_phase)
                PH_NORMAL: o_cmd.kind = (w_c == AMP_CODE) ? CMD_NONE : CMD_CHAR;
                PH_AMP:    o_cmd.kind = w_is_hex ? CMD_NONE : CMD_NO_DIGIT;
                PH_DIGITS: begin
                    o_cmd.kind = w_is_hex ? CMD_NONE : CMD_CHAR;
                    o_cmd.chr  = r_acc & UnitMask;
                end
                PH_SKIP:   o_cmd.kind = CMD_NONE;
                default:   o_cmd.kind = CMD_NONE;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_ENCODE;
            r_phase <= PH_NORMAL;
            r_acc   <= 16'd0;
        end else begin
            if (i_cfg_valid) begin
                r_dir <= i_cfg_data;
            end
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

endmodule

[hdl/ahe_queue.sv]
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module ahe_queue #(
    parameter int DEPTH = ahe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ahe_pkg::t_cmd i_cmd,
    output logic          o_space,
    input  logic          i_pop,
    output logic          o_valid,
    output ahe_pkg::t_cmd o_cmd
);
    import ahe_pkg::*;

    localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntBits = $clog2(DEPTH + 1);

    t_cmd               r_mem [DEPTH];
    logic [PtrBits-1:0] r_wr_ptr;
    logic [PtrBits-1:0] r_rd_ptr;
    logic [CntBits-1:0] r_count;

    assign o_space = (r_count != CntBits'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrBits'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrBits'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hdl/ahe_back.sv]
// Back end: expands each command into its result items behind an output register.
`timescale 1ns / 1ps

module ahe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ahe_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ahe_pkg::t_result o_result,
    output logic          o_out_last
);
    import ahe_pkg::*;

    logic [2:0]  r_step;
    logic [2:0]  w_n_main;
    logic [2:0]  w_total;
    logic [2:0]  w_nib_idx;
    logic [3:0]  w_nib;
    logic        w_fin;
    logic        w_load;
    logic        w_adv;
    t_result     w_res;
    logic        r_out_valid;
    t_result     r_result;
    logic        r_out_last;

    // Number of results the command gives.
    always_comb begin
        case (i_cmd.kind)
            CMD_CHAR, CMD_NO_DIGIT: w_n_main = 3'd1;
            CMD_ESCAPE:             w_n_main = i_cmd.ndig + 3'd2;
            default:                w_n_main = 3'd0;
        endcase
        w_total = w_n_main + {2'd0, i_cmd.err2};
        if (w_total == 3'd0) begin
            w_total = 3'd1;
        end
    end

    // Nibble shown at the current escape step, most significant first.
    assign w_nib_idx = i_cmd.ndig - r_step;
    always_comb begin
        case (w_nib_idx[1:0])
            2'd0:    w_nib = i_cmd.chr[3:0];
            2'd1:    w_nib = i_cmd.chr[7:4];
            2'd2:    w_nib = i_cmd.chr[11:8];
            default: w_nib = i_cmd.chr[15:12];
        endcase
    end

    // Result of the current step.
    always_comb begin
        w_res.chr   = 16'd0;
        w_res.valid = 1'b0;
        w_res.err   = ERR_NONE;
        if (r_step < w_n_main) begin
            case (i_cmd.kind)
                CMD_CHAR: begin
                    w_res.chr   = i_cmd.chr;
                    w_res.valid = 1'b1;
                end
                CMD_ESCAPE: begin
                    w_res.valid = 1'b1;
                    if (r_step == 3'd0) begin
                        w_res.chr = AMP_CODE;
                    end else if (r_step == w_n_main - 3'd1) begin
                        w_res.chr = SEMI_CODE;
                    end else begin
                        w_res.chr = hex_ascii(w_nib);
                    end
                end
                CMD_NO_DIGIT: w_res.err = ERR_NO_DIGIT;
                default:      w_res.err = ERR_NONE;
            endcase
        end else if (i_cmd.err2 && r_step == w_n_main) begin
            w_res.err = ERR_UNTERMINATED;
        end
    end

    assign w_fin  = (r_step == w_total - 3'd1);
    assign w_load = !r_out_valid || i_out_ready;
    assign w_adv  = w_load && i_valid;
    assign o_pop  = w_adv && w_fin;

    // Step counter within the current command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_step <= w_fin ? 3'd0 : r_step + 3'd1;
            end
            if (w_load) begin
                r_out_valid <= i_valid;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result   <= w_res;
            r_out_last <= i_cmd.last && w_fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign o_out_last  = r_out_last;

endmodule

[hdl/ampersand_hex_escape_codec.sv]
// Top level of the ampersand hex escape codec.
`timescale 1ns / 1ps

// Streams 16-bit code units through an ampersand hex escape codec. With the
// direction register at 0, control characters, whitespace and '&' become '&',
// uppercase hex digits without leading zeros and ';' (three to six results),
// and every other unit passes as one result. With direction 1, '&' opens an
// escape, hex digits accumulate, the first non-hex unit emits the character
// and input is skipped through ';'; a missing digit or text that ends inside
// an escape gives a result with char_valid low and an error code. The front
// end is combinational and accepts one unit per cycle while the queue has
// space; the back end emits one result per cycle while the output is ready,
// so a unit with an escape holds the output for each of its results, and a
// command queue (four by default) between the two absorbs those bursts before
// input is held off. Units that give no result and do not end the text queue
// nothing. Write the direction register only while the block is idle.
module ampersand_hex_escape_codec #(
    parameter int CHAR_BITS   = ahe_pkg::CHAR_BITS_DEF,
    parameter int QUEUE_DEPTH = ahe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel: direction, 0 encode, 1 decode.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] in_char
    input  logic        i_s_tlast,   // in_last
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [15:0] out_char, [16] char_valid, [18:17] error_code
    output logic        o_m_tlast    // out_last
);
    import ahe_pkg::*;

    logic    w_push;
    logic    w_space;
    logic    w_pop;
    logic    w_q_valid;
    t_cmd    w_cmd_in;
    t_cmd    w_cmd_out;
    t_result w_result;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = w_space;

    // Front end: classification and decoder state.
    ahe_front #(
        .CHAR_BITS (CHAR_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .i_char      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_space     (w_space),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in)
    );

    // Command queue.
    ahe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_space (w_space),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_cmd_out)
    );

    // Back end: result expansion and output register.
    ahe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_result    (w_result),
        .o_out_last  (o_m_tlast)
    );

    assign o_m_tdata = {5'd0, w_result};

endmodule
